@@ design/pcc_pkg.sv @@
// Package with item types, control word format, datapath constants and the microcode table.
package pcc_pkg;

	typedef struct packed {
		logic signed [15:0] err_value;
		logic signed [15:0] err_rate;
		logic        [15:0] time_step;
		logic               clear_integral;
	} in_item_t;

	typedef struct packed {
		logic signed [13:0] command;
		logic               saturated;
	} out_item_t;

	localparam int GAIN_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEGRAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;

	localparam int ACC_W = 40;
	localparam int WORK_W = 57;
	localparam int PROD_W = 37;
	localparam int ITERM_W = 22;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh7FFFFFFFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 40'sh8000000000;
	localparam logic signed [WORK_W-1:0] ILIM_POS = 57'sd103079215104;
	localparam logic signed [WORK_W-1:0] ILIM_NEG = -57'sd103079215104;
	localparam logic signed [WORK_W-1:0] CLIM_POS = 57'sd1572864;
	localparam logic signed [WORK_W-1:0] CLIM_NEG = -57'sd1572864;
	localparam logic signed [13:0] CMD_MAX = 14'sd6144;
	localparam logic signed [13:0] CMD_MIN = -14'sd6144;

	localparam logic [2:0] MUL_ERR_DT = 3'd0;
	localparam logic [2:0] MUL_GI_HI = 3'd1;
	localparam logic [2:0] MUL_GI_LO = 3'd2;
	localparam logic [2:0] MUL_GP_ERR = 3'd3;
	localparam logic [2:0] MUL_GD_RATE = 3'd4;

	localparam logic [1:0] INTEG_HOLD = 2'd0;
	localparam logic [1:0] INTEG_CLR_IF_FLAG = 2'd1;
	localparam logic [1:0] INTEG_ADD_SAT = 2'd2;
	localparam logic [1:0] INTEG_ZERO = 2'd3;

	localparam logic [1:0] WORK_HOLD = 2'd0;
	localparam logic [1:0] WORK_LOAD_HI = 2'd1;
	localparam logic [1:0] WORK_ADD = 2'd2;
	localparam logic [1:0] WORK_LOAD_PI = 2'd3;

	localparam logic [1:0] ITERM_HOLD = 2'd0;
	localparam logic [1:0] ITERM_CLAMP = 2'd1;
	localparam logic [1:0] ITERM_ZERO = 2'd2;

	localparam logic [1:0] JMP_NONE = 2'd0;
	localparam logic [1:0] JMP_ALWAYS = 2'd1;
	localparam logic [1:0] JMP_GI_ZERO = 2'd2;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_ERR_DT = 4'd0;
	localparam logic [STEP_W-1:0] ST_ACCUM = 4'd1;
	localparam logic [STEP_W-1:0] ST_MUL_HI = 4'd2;
	localparam logic [STEP_W-1:0] ST_MUL_LO = 4'd3;
	localparam logic [STEP_W-1:0] ST_ADD_LO = 4'd4;
	localparam logic [STEP_W-1:0] ST_ITERM = 4'd5;
	localparam logic [STEP_W-1:0] ST_MUL_D = 4'd6;
	localparam logic [STEP_W-1:0] ST_ADD_D = 4'd7;
	localparam logic [STEP_W-1:0] ST_EMIT = 4'd8;
	localparam logic [STEP_W-1:0] ST_NO_INTEG = 4'd9;

	typedef struct packed {
		logic [2:0]        mul_sel;
		logic [1:0]        integ_op;
		logic [1:0]        work_op;
		logic [1:0]        iterm_op;
		logic [1:0]        jmp;
		logic [STEP_W-1:0] target;
		logic              emit;
		logic              last;
	} ctrl_word_t;

	typedef struct packed {
		logic busy;
		logic en;
		logic done;
	} seq_stat_t;

	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw = '0;
		case (step)
			ST_ERR_DT: begin
				cw.mul_sel = MUL_ERR_DT;
				cw.integ_op = INTEG_CLR_IF_FLAG;
				cw.jmp = JMP_GI_ZERO;
				cw.target = ST_NO_INTEG;
			end
			ST_ACCUM: begin
				cw.integ_op = INTEG_ADD_SAT;
			end
			ST_MUL_HI: begin
				cw.mul_sel = MUL_GI_HI;
			end
			ST_MUL_LO: begin
				cw.mul_sel = MUL_GI_LO;
				cw.work_op = WORK_LOAD_HI;
			end
			ST_ADD_LO: begin
				cw.work_op = WORK_ADD;
			end
			ST_ITERM: begin
				cw.iterm_op = ITERM_CLAMP;
				cw.mul_sel = MUL_GP_ERR;
			end
			ST_MUL_D: begin
				cw.mul_sel = MUL_GD_RATE;
				cw.work_op = WORK_LOAD_PI;
			end
			ST_ADD_D: begin
				cw.work_op = WORK_ADD;
			end
			ST_EMIT: begin
				cw.emit = 1'b1;
				cw.last = 1'b1;
			end
			ST_NO_INTEG: begin
				cw.integ_op = INTEG_ZERO;
				cw.iterm_op = ITERM_ZERO;
				cw.mul_sel = MUL_GP_ERR;
				cw.jmp = JMP_ALWAYS;
				cw.target = ST_MUL_D;
			end
			default: begin
				cw.last = 1'b1;
			end
		endcase
		return cw;
	endfunction

endpackage

@@ design/pcc_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional and unconditional jumps.
module pcc_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  gi_zero,
	input  logic                  out_blocked,
	output pcc_pkg::ctrl_word_t   cw,
	output pcc_pkg::seq_stat_t    stat
);

	logic                       busy_q;
	logic [pcc_pkg::STEP_W-1:0] step_q;
	logic                       jump_taken;

	assign cw = pcc_pkg::ucode(step_q);
	assign stat.busy = busy_q;
	assign stat.en = busy_q && !(cw.emit && out_blocked);
	assign stat.done = stat.en && cw.last;

	always_comb begin
		case (cw.jmp)
			pcc_pkg::JMP_ALWAYS:  jump_taken = 1'b1;
			pcc_pkg::JMP_GI_ZERO: jump_taken = gi_zero;
			default:              jump_taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= pcc_pkg::ST_ERR_DT;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= pcc_pkg::ST_ERR_DT;
		end else if (stat.en) begin
			if (cw.last) begin
				busy_q <= 1'b0;
			end else if (jump_taken) begin
				step_q <= cw.target;
			end else begin
				step_q <= step_q + {{(pcc_pkg::STEP_W-1){1'b0}}, 1'b1};
			end
		end
	end

endmodule

@@ design/pcc_datapath.sv @@
// Datapath with one shared multiplier, integral accumulator, work register and result register.
module pcc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  pcc_pkg::in_item_t           in_data,
	input  logic signed [15:0]          gain_prop,
	input  logic signed [15:0]          gain_integral,
	input  logic signed [15:0]          gain_deriv,
	input  pcc_pkg::ctrl_word_t         cw,
	input  logic                        en,
	output pcc_pkg::out_item_t          out_data
);

	logic signed [15:0]                  err_q;
	logic signed [15:0]                  rate_q;
	logic [15:0]                         dt_q;
	logic                                clr_q;
	logic signed [pcc_pkg::ACC_W-1:0]    integ_q;
	logic signed [pcc_pkg::PROD_W-1:0]   prod_q;
	logic signed [pcc_pkg::WORK_W-1:0]   work_q;
	logic signed [pcc_pkg::ITERM_W-1:0]  iterm_q;
	pcc_pkg::out_item_t                  out_q;

	logic signed [15:0]                  mul_a;
	logic signed [20:0]                  mul_b;
	logic signed [pcc_pkg::PROD_W-1:0]   mul_p;
	logic signed [pcc_pkg::ACC_W:0]      isum;
	logic signed [pcc_pkg::WORK_W-1:0]   prod_ext;
	logic signed [pcc_pkg::WORK_W-1:0]   iclamp;
	logic signed [pcc_pkg::WORK_W-1:0]   sclamp;
	logic                                sat;

	always_comb begin
		case (cw.mul_sel)
			pcc_pkg::MUL_ERR_DT: begin
				mul_a = err_q;
				mul_b = $signed({5'b0, dt_q});
			end
			pcc_pkg::MUL_GI_HI: begin
				mul_a = gain_integral;
				mul_b = $signed({integ_q[39], integ_q[39:20]});
			end
			pcc_pkg::MUL_GI_LO: begin
				mul_a = gain_integral;
				mul_b = $signed({1'b0, integ_q[19:0]});
			end
			pcc_pkg::MUL_GP_ERR: begin
				mul_a = gain_prop;
				mul_b = $signed({{5{err_q[15]}}, err_q});
			end
			pcc_pkg::MUL_GD_RATE: begin
				mul_a = gain_deriv;
				mul_b = $signed({{5{rate_q[15]}}, rate_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign isum = $signed({integ_q[39], integ_q}) + $signed({{4{prod_q[36]}}, prod_q});
	assign prod_ext = $signed({{20{prod_q[36]}}, prod_q});

	always_comb begin
		if (work_q > pcc_pkg::ILIM_POS) begin
			iclamp = pcc_pkg::ILIM_POS;
		end else if (work_q < pcc_pkg::ILIM_NEG) begin
			iclamp = pcc_pkg::ILIM_NEG;
		end else begin
			iclamp = work_q;
		end
	end

	always_comb begin
		if (work_q > pcc_pkg::CLIM_POS) begin
			sclamp = pcc_pkg::CLIM_POS;
			sat = 1'b1;
		end else if (work_q < pcc_pkg::CLIM_NEG) begin
			sclamp = pcc_pkg::CLIM_NEG;
			sat = 1'b1;
		end else begin
			sclamp = work_q;
			sat = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= in_data.err_value;
			rate_q <= in_data.err_rate;
			dt_q <= in_data.time_step;
			clr_q <= in_data.clear_integral;
		end
		if (en) begin
			prod_q <= mul_p;
			case (cw.work_op)
				pcc_pkg::WORK_LOAD_HI: work_q <= {prod_q, 20'b0};
				pcc_pkg::WORK_ADD:     work_q <= work_q + prod_ext;
				pcc_pkg::WORK_LOAD_PI: work_q <= prod_ext + $signed({{35{iterm_q[21]}}, iterm_q});
				default:               work_q <= work_q;
			endcase
			case (cw.iterm_op)
				pcc_pkg::ITERM_CLAMP: iterm_q <= iclamp[37:16];
				pcc_pkg::ITERM_ZERO:  iterm_q <= '0;
				default:              iterm_q <= iterm_q;
			endcase
			if (cw.emit) begin
				out_q.command <= sclamp[21:8];
				out_q.saturated <= sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (en) begin
			case (cw.integ_op)
				pcc_pkg::INTEG_CLR_IF_FLAG: begin
					if (clr_q) begin
						integ_q <= '0;
					end
				end
				pcc_pkg::INTEG_ADD_SAT: begin
					if (isum[40] != isum[39]) begin
						integ_q <= isum[40] ? pcc_pkg::ACC_MIN : pcc_pkg::ACC_MAX;
					end else begin
						integ_q <= isum[39:0];
					end
				end
				pcc_pkg::INTEG_ZERO: integ_q <= '0;
				default:             integ_q <= integ_q;
			endcase
		end
	end

	assign out_data = out_q;

endmodule

@@ design/pid_controller_clamped_unit.sv @@
// Top level of the clamped PID controller: handshakes, gain registers and assertions.
// The microcode program runs the products through the single shared multiplier in turn:
// all five, or only the error-time, proportional and derivative ones when gain_integral
// is zero. The emit step stalls while the output holds an item that is not yet taken.
// A new item is taken in the cycle the previous item's result is written to the output register.
// Reset clears the gains, the integral accumulator, the sequencer and the output valid flag.
module pid_controller_clamped_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pcc_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pcc_pkg::out_item_t   out_data,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);

	logic signed [15:0]   gain_prop_q;
	logic signed [15:0]   gain_integral_q;
	logic signed [15:0]   gain_deriv_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 emit_fire;
	pcc_pkg::ctrl_word_t  cw;
	pcc_pkg::seq_stat_t   stat;

	assign in_ready = !stat.busy || stat.done;
	assign accept = in_valid && in_ready;
	assign emit_fire = stat.en && cw.emit;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q <= '0;
			gain_integral_q <= '0;
			gain_deriv_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pcc_pkg::CFG_GAIN_PROP:     gain_prop_q <= cfg_wdata;
				pcc_pkg::CFG_GAIN_INTEGRAL: gain_integral_q <= cfg_wdata;
				pcc_pkg::CFG_GAIN_DERIV:    gain_deriv_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	pcc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.gi_zero     (gain_integral_q == 16'sd0),
		.out_blocked (out_valid_q && !out_ready),
		.cw          (cw),
		.stat        (stat)
	);

	pcc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_data       (in_data),
		.gain_prop     (gain_prop_q),
		.gain_integral (gain_integral_q),
		.gain_deriv    (gain_deriv_q),
		.cw            (cw),
		.en            (stat.en),
		.out_data      (out_data)
	);

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.command <= pcc_pkg::CMD_MAX &&
			out_data.command >= pcc_pkg::CMD_MIN))
		else $error("command outside the clamp range");

	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			(out_data.command == pcc_pkg::CMD_MAX || out_data.command == pcc_pkg::CMD_MIN))
		else $error("saturated flag set but command not at a bound");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> stat.busy)
		else $error("accepted item did not start the sequencer");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> (!out_valid_q || out_ready))
		else $error("result written over an item not yet taken");

endmodule
